### rtl/assert_macros.svh
// Assertion macros for the point projection block.
// Used by the top level only; expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LPVP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPVP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lpvp_pkg.sv
// Shared types, constants and functions for the lidar point projection.
// No dependencies.
package lpvp_pkg;

  localparam int BIRD_SIZE     = 1000;
  localparam int VIEW_COLS     = 1125;
  localparam int VIEW_ROWS     = 32;
  localparam int HEIGHT_SLICES = 8;

  localparam int HALF_MM  = 50000;
  localparam int LOW_Z_MM = -3000;
  localparam int TOP_Z_MM = 1000;

  localparam int CORDIC_STEPS = 17;
  localparam int CW           = 27;  // CORDIC datapath width
  localparam int AW           = 18;  // angle width, 2^-16 rad units
  localparam int NW           = 37;  // view numerator width

  localparam int SQ_RAD_W  = 50;
  localparam int SQ_ROOT_W = SQ_RAD_W / 2;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_STEPS  = SQ_ROOT_W;

  // reciprocal multipliers, exact over the value ranges used
  localparam int BIRD_RECIP  = 167773;     // 2^24 / 100
  localparam int SLICE_RECIP = 33555;      // 2^24 / 500
  localparam int LVL_RECIP   = 273804210;  // 255 * 2^32 / 4000
  localparam int RNG_RECIP   = 67109;      // 2^26 / 1000
  localparam int COL_RECIP   = 52429;      // 2^19 / 10
  localparam int ROW_RECIP   = 16778;      // 2^21 / 125

  typedef logic signed [17:0]         coord_t;
  typedef logic signed [CW-1:0]       cw_t;
  typedef logic signed [AW-1:0]       ang_t;
  typedef logic signed [NW-1:0]       num_t;
  typedef logic [SQ_RAD_W-1:0]        rad_t;
  typedef logic [SQ_ROOT_W-1:0]       root_t;
  typedef logic [SQ_REM_W-1:0]        rem_t;

  typedef struct packed {
    logic        inb;
    logic [9:0]  brow;
    logic [9:0]  bcol;
    logic [2:0]  slice;
    logic        back;
    logic [7:0]  lvl;
    logic        zero_a;
    logic        zero_e;
    cw_t         z256;
    ang_t        ang_a;
    ang_t        ang_e;
    logic [7:0]  rng;
    num_t        num_a;
    num_t        num_e;
    logic [11:0] qa;
    logic [8:0]  qe;
    logic        neg_a;
    logic        neg_e;
    logic [10:0] col;
    logic [4:0]  row;
  } side_t;

  // atan(2^-i) * 65536, rounded
  function automatic ang_t atan_step(input logic [4:0] i);
    ang_t a;
    case (i)
      5'd0:    a = 18'sd51472;
      5'd1:    a = 18'sd30386;
      5'd2:    a = 18'sd16055;
      5'd3:    a = 18'sd8150;
      5'd4:    a = 18'sd4091;
      5'd5:    a = 18'sd2047;
      5'd6:    a = 18'sd1024;
      5'd7:    a = 18'sd512;
      5'd8:    a = 18'sd256;
      5'd9:    a = 18'sd128;
      5'd10:   a = 18'sd64;
      5'd11:   a = 18'sd32;
      5'd12:   a = 18'sd16;
      5'd13:   a = 18'sd8;
      5'd14:   a = 18'sd4;
      5'd15:   a = 18'sd2;
      5'd16:   a = 18'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // BIRD_SIZE - ceil((c + 50 m) / 0.1 m), clamped; c within the box
  // (c on the far negative face gives BIRD_SIZE, clamped to the last cell)
  function automatic logic [9:0] bird_idx(input coord_t c);
    logic [16:0] t;
    logic [34:0] p;
    logic [10:0] q;
    t = 17'(c + 18'sd50099);
    p = 35'(t) * 35'(BIRD_RECIP);
    q = p[34:24];
    return (q >= 11'(BIRD_SIZE)) ? 10'd0 :
           (q == '0) ? 10'(BIRD_SIZE - 1) : 10'(11'(BIRD_SIZE) - q);
  endfunction

endpackage

### rtl/lpvp_in_if.sv
// Point input channel: valid/ready handshake with x, y, z in millimetres.
// Depends on lpvp_pkg.
interface lpvp_in_if;
  logic            valid;
  logic            ready;
  lpvp_pkg::coord_t x_mm;
  lpvp_pkg::coord_t y_mm;
  lpvp_pkg::coord_t z_mm;

  modport source(output valid, x_mm, y_mm, z_mm, input ready);
  modport sink(input valid, x_mm, y_mm, z_mm, output ready);
endinterface

### rtl/lpvp_out_if.sv
// Projection result channel: valid/ready handshake with the projected fields.
// No dependencies.
interface lpvp_out_if;
  logic        valid;
  logic        ready;
  logic        in_range;
  logic [9:0]  bird_row;
  logic [9:0]  bird_col;
  logic [2:0]  height_slice;
  logic        is_back;
  logic [4:0]  view_row;
  logic [10:0] view_col;
  logic [7:0]  height_level;
  logic [7:0]  range_m;

  modport source(output valid, in_range, bird_row, bird_col, height_slice, is_back,
                 view_row, view_col, height_level, range_m, input ready);
  modport sink(input valid, in_range, bird_row, bird_col, height_slice, is_back,
               view_row, view_col, height_level, range_m, output ready);
endinterface

### rtl/lidar_point_view_projection.sv
// Lidar point projection top: box test, bird/slice/level, two root chains, two CORDIC chains.
// Depends on lpvp_pkg, lpvp_in_if, lpvp_out_if, lpvp_sqrt_cell, lpvp_cordic_cell.
//
//  channel | dir | contents
//  pt      | in  | x_mm, y_mm, z_mm (signed mm)
//  res     | out | in_range, bird_row/col, height_slice, is_back, view_row/col,
//          |     | height_level, range_m
//
// One transaction per cycle unless a result held at the output stalls the pipeline.
// The longest path is the planar root chain (25 cells) feeding the elevation CORDIC
// chain (17 cells). All stages advance together; a result held at the output
// stalls the whole row of cells, so pt.ready follows res.ready in that case.
// Synchronous reset clears stage valid bits only.
`include "assert_macros.svh"

module lidar_point_view_projection (
  input logic         clk,
  input logic         rst,
  lpvp_in_if.sink     pt,
  lpvp_out_if.source  res
);
  localparam int NS    = lpvp_pkg::CORDIC_STEPS;
  localparam int NQ    = lpvp_pkg::SQ_STEPS;
  localparam int S_CA  = 2 + NS;      // azimuth angle ready
  localparam int S_SQ  = 3 + NQ;      // roots ready
  localparam int S_CE  = S_SQ + NS;   // elevation angle ready
  localparam int S_END = S_CE + 4;

  logic             en;
  logic [S_END:1]   vld;

  lpvp_pkg::coord_t x1, y1, z1;
  lpvp_pkg::side_t  s2_d;
  lpvp_pkg::side_t  side   [2:S_END];
  lpvp_pkg::side_t  side_d [3:S_END];

  logic [31:0]      sqx, sqy;
  logic [23:0]      sqz;
  lpvp_pkg::rad_t   rad_a, rad_b;

  lpvp_pkg::cw_t    ca_x [0:NS];
  lpvp_pkg::cw_t    ca_y [0:NS];
  lpvp_pkg::ang_t   ca_z [0:NS];
  lpvp_pkg::cw_t    ce_x [0:NS];
  lpvp_pkg::cw_t    ce_y [0:NS];
  lpvp_pkg::ang_t   ce_z [0:NS];

  lpvp_pkg::rad_t   qa_rad  [0:NQ];
  lpvp_pkg::rem_t   qa_rem  [0:NQ];
  lpvp_pkg::root_t  qa_root [0:NQ];
  lpvp_pkg::rad_t   qb_rad  [0:NQ];
  lpvp_pkg::rem_t   qb_rem  [0:NQ];
  lpvp_pkg::root_t  qb_root [0:NQ];

  // stage-2 combinational
  logic             inb;
  lpvp_pkg::coord_t xm, ym, zm;
  logic [15:0]      ax, ay;
  logic [11:0]      az, zt;
  logic [27:0]      slp;
  logic [40:0]      lvp;
  logic [3:0]       slq;

  assign en       = !vld[S_END] || res.ready;
  assign pt.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_END-1:1], pt.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= pt.x_mm;
      y1 <= pt.y_mm;
      z1 <= pt.z_mm;
    end
  end

  always_comb begin
    inb = (x1 <= 18'sd50000) && (x1 >= -18'sd50000) &&
          (y1 <= 18'sd50000) && (y1 >= -18'sd50000) &&
          (z1 <= 18'(lpvp_pkg::TOP_Z_MM)) && (z1 >= 18'(lpvp_pkg::LOW_Z_MM));
    // out-of-box points run through the chains as the origin; result masked later
    xm  = inb ? x1 : '0;
    ym  = inb ? y1 : '0;
    zm  = inb ? z1 : '0;
    ax  = 16'(xm[17] ? -xm : xm);
    ay  = 16'(ym[17] ? -ym : ym);
    az  = 12'(zm[17] ? -zm : zm);
    zt  = 12'(zm - 18'(lpvp_pkg::LOW_Z_MM));
    slp = 28'(zt) * 28'(lpvp_pkg::SLICE_RECIP);
    slq = slp[27:24];
    lvp = 41'(zt) * 41'(lpvp_pkg::LVL_RECIP);

    s2_d        = '0;
    s2_d.inb    = inb;
    s2_d.brow   = lpvp_pkg::bird_idx(xm);
    s2_d.bcol   = lpvp_pkg::bird_idx(ym);
    s2_d.slice  = (slq > 4'(lpvp_pkg::HEIGHT_SLICES - 1)) ?
                  3'(lpvp_pkg::HEIGHT_SLICES - 1) : slq[2:0];
    s2_d.back   = xm[17];
    s2_d.lvl    = lvp[39:32];
    s2_d.zero_a = (xm == '0) && (ym == '0);
    s2_d.zero_e = (xm == '0) && (ym == '0) && (zm == '0);
    s2_d.z256   = lpvp_pkg::cw_t'($signed({zm, 8'b0}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[2] <= s2_d;
      sqx     <= 32'(ax) * 32'(ax);
      sqy     <= 32'(ay) * 32'(ay);
      sqz     <= 24'(az) * 24'(az);
      ca_x[0] <= lpvp_pkg::cw_t'({ax, 8'b0});
      ca_y[0] <= lpvp_pkg::cw_t'($signed({ym, 8'b0}));
      rad_a   <= lpvp_pkg::SQ_RAD_W'({33'(sqx) + 33'(sqy), 16'b0});
      rad_b   <= lpvp_pkg::SQ_RAD_W'(34'(sqx) + 34'(sqy) + 34'(sqz));
      for (int k = 3; k <= S_END; k++) begin
        side[k] <= side_d[k];
      end
    end
  end

  assign ca_z[0]    = '0;
  assign qa_rad[0]  = rad_a;
  assign qa_rem[0]  = '0;
  assign qa_root[0] = '0;
  assign qb_rad[0]  = rad_b;
  assign qb_rem[0]  = '0;
  assign qb_root[0] = '0;
  assign ce_x[0]    = lpvp_pkg::cw_t'(qa_root[NQ]);
  assign ce_y[0]    = side[S_SQ].z256;
  assign ce_z[0]    = '0;

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    lpvp_cordic_cell u_az (
      .clk(clk), .en(en), .step(5'(i)),
      .x_in(ca_x[i]), .y_in(ca_y[i]), .z_in(ca_z[i]),
      .x_out(ca_x[i+1]), .y_out(ca_y[i+1]), .z_out(ca_z[i+1])
    );
    lpvp_cordic_cell u_el (
      .clk(clk), .en(en), .step(5'(i)),
      .x_in(ce_x[i]), .y_in(ce_y[i]), .z_in(ce_z[i]),
      .x_out(ce_x[i+1]), .y_out(ce_y[i+1]), .z_out(ce_z[i+1])
    );
  end

  for (genvar j = 0; j < NQ; j++) begin : g_sqrt
    lpvp_sqrt_cell u_plan (
      .clk(clk), .en(en),
      .rad_in(qa_rad[j]), .rem_in(qa_rem[j]), .root_in(qa_root[j]),
      .rad_out(qa_rad[j+1]), .rem_out(qa_rem[j+1]), .root_out(qa_root[j+1])
    );
    lpvp_sqrt_cell u_full (
      .clk(clk), .en(en),
      .rad_in(qb_rad[j]), .rem_in(qb_rem[j]), .root_in(qb_root[j]),
      .rad_out(qb_rad[j+1]), .rem_out(qb_rem[j+1]), .root_out(qb_root[j+1])
    );
  end

  // sideband: carried stage to stage, with results dropped in where they appear
  logic [33:0] rngp;
  logic [30:0] colp;
  logic [29:0] rowp;
  logic [8:0]  rowm;

  always_comb begin
    for (int k = 3; k <= S_END; k++) begin
      side_d[k] = side[k-1];
    end
    side_d[S_CA+1].ang_a = side[S_CA].zero_a ? '0 : ca_z[NS];

    rngp = 34'(qb_root[NQ][16:0]) * 34'(lpvp_pkg::RNG_RECIP);
    side_d[S_SQ+1].rng = rngp[33:26];

    side_d[S_CE+1].ang_e = side[S_CE].zero_e ? '0 : ce_z[NS];

    side_d[S_CE+2].num_a = 37'sd5898240000 -
                           lpvp_pkg::num_t'(side[S_CE+1].ang_a) * 37'sd57325;
    side_d[S_CE+2].num_e = 37'sd2359296000 -
                           lpvp_pkg::num_t'(side[S_CE+1].ang_e) * 37'sd171975;

    colp = 31'(side[S_CE+2].num_a[34:20]) * 31'(lpvp_pkg::COL_RECIP);
    rowp = 30'(side[S_CE+2].num_e[35:21]) * 30'(lpvp_pkg::ROW_RECIP);
    side_d[S_CE+3].qa    = colp[30:19];
    side_d[S_CE+3].qe    = rowp[29:21];
    side_d[S_CE+3].neg_a = side[S_CE+2].num_a[lpvp_pkg::NW-1];
    side_d[S_CE+3].neg_e = side[S_CE+2].num_e[lpvp_pkg::NW-1];

    rowm = side[S_CE+3].qe - 9'd1;
    if (side[S_CE+3].neg_a) begin
      side_d[S_END].col = '0;
    end else if (side[S_CE+3].qa > 12'(lpvp_pkg::VIEW_COLS - 1)) begin
      side_d[S_END].col = 11'(lpvp_pkg::VIEW_COLS - 1);
    end else begin
      side_d[S_END].col = side[S_CE+3].qa[10:0];
    end
    if (side[S_CE+3].neg_e || side[S_CE+3].qe == '0) begin
      side_d[S_END].row = '0;
    end else if (rowm > 9'(lpvp_pkg::VIEW_ROWS - 1)) begin
      side_d[S_END].row = 5'(lpvp_pkg::VIEW_ROWS - 1);
    end else begin
      side_d[S_END].row = rowm[4:0];
    end
    if (!side[S_CE+3].inb) begin
      side_d[S_END] = '0;
    end
  end

  assign res.valid        = vld[S_END];
  assign res.in_range     = side[S_END].inb;
  assign res.bird_row     = side[S_END].brow;
  assign res.bird_col     = side[S_END].bcol;
  assign res.height_slice = side[S_END].slice;
  assign res.is_back      = side[S_END].back;
  assign res.view_row     = side[S_END].row;
  assign res.view_col     = side[S_END].col;
  assign res.height_level = side[S_END].lvl;
  assign res.range_m      = side[S_END].rng;

  `LPVP_ASSERT_IMP(a_out_zero, res.valid && !res.in_range, res.bird_row == '0 && res.bird_col == '0 && res.view_col == '0 && res.range_m == '0 && res.height_level == '0, "out-of-box result carries nonzero fields")
  `LPVP_ASSERT_IMP(a_out_bounds, res.valid && res.in_range, res.view_col <= 11'(lpvp_pkg::VIEW_COLS - 1) && res.bird_row <= 10'(lpvp_pkg::BIRD_SIZE - 1) && res.bird_col <= 10'(lpvp_pkg::BIRD_SIZE - 1), "result index off the grid")
  `LPVP_ASSERT_NXT(a_take, pt.valid && pt.ready, vld[1], "accepted transaction not in first stage")
  `LPVP_ASSERT_NXT(a_hold, !en, $stable(vld), "pipeline moved while stalled")

endmodule

### rtl/lpvp_sqrt_cell.sv
// One digit of a pipelined integer square root: two radicand bits in, one root bit out.
// Depends on lpvp_pkg.
module lpvp_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  lpvp_pkg::rad_t  rad_in,
  input  lpvp_pkg::rem_t  rem_in,
  input  lpvp_pkg::root_t root_in,
  output lpvp_pkg::rad_t  rad_out,
  output lpvp_pkg::rem_t  rem_out,
  output lpvp_pkg::root_t root_out
);
  localparam int RW = lpvp_pkg::SQ_REM_W + 2;

  logic [RW-1:0] rw;
  logic [RW-1:0] trial;
  logic          fit;

  assign rw    = {rem_in, rad_in[lpvp_pkg::SQ_RAD_W-1 -: 2]};
  assign trial = {2'b00, root_in, 2'b01};
  assign fit   = rw >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out <= {rad_in[lpvp_pkg::SQ_RAD_W-3:0], 2'b00};
      if (fit) begin
        rem_out  <= lpvp_pkg::SQ_REM_W'(rw - trial);
        root_out <= {root_in[lpvp_pkg::SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem_out  <= rw[lpvp_pkg::SQ_REM_W-1:0];
        root_out <= {root_in[lpvp_pkg::SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end
endmodule

### rtl/lpvp_cordic_cell.sv
// One vectoring CORDIC iteration, registered; the step index selects shift and angle.
// Depends on lpvp_pkg.
module lpvp_cordic_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     step,
  input  lpvp_pkg::cw_t  x_in,
  input  lpvp_pkg::cw_t  y_in,
  input  lpvp_pkg::ang_t z_in,
  output lpvp_pkg::cw_t  x_out,
  output lpvp_pkg::cw_t  y_out,
  output lpvp_pkg::ang_t z_out
);
  lpvp_pkg::cw_t  dx;
  lpvp_pkg::cw_t  dy;
  lpvp_pkg::ang_t da;

  assign dx = y_in >>> step;
  assign dy = x_in >>> step;
  assign da = lpvp_pkg::atan_step(step);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[lpvp_pkg::CW-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + da;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - da;
      end
    end
  end
endmodule
